@@ design/cqwa_pkg.sv @@
// Shared types and constants for the circular queue window average block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cqwa_pkg;

   localparam int SLOTS_DEF     = 8;
   localparam int ID_W          = 10;
   localparam int RATE_W        = 8;
   localparam int AVG_W         = 8;
   localparam int STATUS_W      = 2;
   localparam int DIV_BITS_STEP = 2;
   localparam int DIV_STEPS     = AVG_W / DIV_BITS_STEP;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_INSERT = 2'd0;
   localparam logic [STATUS_W-1:0] ST_REMOVE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVICT,
      S_REMOVE,
      S_INSERT,
      S_DIVIDE
   } state_type;

endpackage

`default_nettype wire

@@ design/circular_queue_window_average.sv @@
// Top level: circular queue of identifier/rate words in one memory, with a running
// rate sum and the rounded mean after each insert. Depends on cqwa_pkg, cqwa_div.
//
// Issue a word with start while busy is low; exactly one result follows on the rsp_
// ports, shown for one cycle with rsp_valid, and must be taken then. A remove reads
// the head word from memory, then updates; a remove on an empty queue answers from
// the idle state without a memory read. An insert first reads the oldest word back
// for eviction when the queue is full; it then writes the word, and the divider for
// the mean retires two quotient bits per cycle. The mean is registered onto rsp_average.
`timescale 1ns / 1ps
`default_nettype none

module circular_queue_window_average #(
   parameter int SLOTS = cqwa_pkg::SLOTS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_mode,
   input  wire logic [cqwa_pkg::ID_W-1:0]     req_item_id,
   input  wire logic [cqwa_pkg::RATE_W-1:0]   req_item_rate,
   output logic                               rsp_valid,
   output logic [cqwa_pkg::STATUS_W-1:0]      rsp_status,
   output logic                               rsp_evicted,
   output logic [cqwa_pkg::ID_W-1:0]          rsp_removed_id,
   output logic [cqwa_pkg::AVG_W-1:0]         rsp_average
);
   import cqwa_pkg::*;

   localparam int IW      = $clog2(SLOTS);
   localparam int CW      = $clog2(SLOTS);
   localparam int SW      = RATE_W + CW;
   localparam int DW      = CW + 1;
   localparam int ENTRY_W = ID_W + RATE_W;

   state_type state_ff, state_in;

   logic [IW-1:0]       head_ff, head_in;
   logic [IW-1:0]       tail_ff, tail_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [SW-1:0]       sum_ff, sum_in;
   logic                mode_ff, mode_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic                evict_ff, evict_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_evicted_ff, rsp_evicted_in;
   logic [ID_W-1:0]     rsp_removed_id_ff, rsp_removed_id_in;
   logic [AVG_W-1:0]    rsp_average_ff, rsp_average_in;

   logic [ENTRY_W-1:0]  mem [SLOTS];
   logic [ENTRY_W-1:0]  rd_data_ff;
   logic                mem_re, mem_we;
   logic [IW-1:0]       mem_waddr;
   logic [ENTRY_W-1:0]  mem_wdata;

   logic [RATE_W-1:0]   rd_rate;
   logic [ID_W-1:0]     rd_id;
   logic [IW-1:0]       head_next, tail_next;
   logic [SW-1:0]       sum_new;
   logic [CW-1:0]       count_new;
   logic [SW:0]         div_num;
   logic [DW-1:0]       div_den;
   logic                div_load, div_done;
   logic [AVG_W-1:0]    div_quo;
   logic                full, empty;

   assign rd_rate   = rd_data_ff[RATE_W-1:0];
   assign rd_id     = rd_data_ff[ENTRY_W-1:RATE_W];
   assign head_next = (head_ff == IW'(SLOTS - 1)) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == IW'(SLOTS - 1)) ? '0 : tail_ff + 1'b1;
   assign full      = (count_ff == CW'(SLOTS - 1));
   assign empty     = (count_ff == '0);
   assign sum_new   = sum_ff + SW'(rate_ff);
   assign count_new = count_ff + 1'b1;
   assign div_num   = {sum_new, 1'b0} + (SW+1)'(count_new);
   assign div_den   = {count_new, 1'b0};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   cqwa_div #(
      .DW(DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .load     (div_load),
      .num      (div_num),
      .den      (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in          = state_ff;
      head_in           = head_ff;
      tail_in           = tail_ff;
      count_in          = count_ff;
      sum_in            = sum_ff;
      mode_in           = mode_ff;
      id_in             = id_ff;
      rate_in           = rate_ff;
      evict_in          = evict_ff;
      rsp_valid_in      = 1'b0;
      rsp_status_in     = rsp_status_ff;
      rsp_evicted_in    = rsp_evicted_ff;
      rsp_removed_id_in = rsp_removed_id_ff;
      rsp_average_in    = rsp_average_ff;
      mem_re            = 1'b0;
      mem_we            = 1'b0;
      mem_waddr         = tail_ff;
      mem_wdata         = {id_ff, rate_ff};
      div_load          = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in  = req_mode;
               id_in    = req_item_id;
               rate_in  = req_item_rate;
               evict_in = 1'b0;
               if (req_mode == MODE_REMOVE) begin
                  if (empty) begin
                     rsp_valid_in      = 1'b1;
                     rsp_status_in     = ST_EMPTY;
                     rsp_evicted_in    = 1'b0;
                     rsp_removed_id_in = '0;
                     rsp_average_in    = '0;
                  end else begin
                     mem_re   = 1'b1;
                     state_in = S_REMOVE;
                  end
               end else if (full) begin
                  mem_re   = 1'b1;
                  state_in = S_EVICT;
               end else begin
                  state_in = S_INSERT;
               end
            end
         end
         S_EVICT: begin
            sum_in   = sum_ff - SW'(rd_rate);
            head_in  = head_next;
            count_in = count_ff - 1'b1;
            evict_in = 1'b1;
            state_in = S_INSERT;
         end
         S_INSERT: begin
            mem_we   = 1'b1;
            tail_in  = tail_next;
            count_in = count_new;
            sum_in   = sum_new;
            div_load = 1'b1;
            state_in = S_DIVIDE;
         end
         S_DIVIDE: begin
            if (div_done) begin
               rsp_valid_in      = 1'b1;
               rsp_status_in     = ST_INSERT;
               rsp_evicted_in    = evict_ff;
               rsp_removed_id_in = '0;
               rsp_average_in    = div_quo;
               state_in          = S_IDLE;
            end
         end
         S_REMOVE: begin
            rsp_valid_in      = 1'b1;
            rsp_status_in     = ST_REMOVE;
            rsp_evicted_in    = 1'b0;
            rsp_removed_id_in = rd_id;
            rsp_average_in    = '0;
            sum_in            = sum_ff - SW'(rd_rate);
            head_in           = head_next;
            count_in          = count_ff - 1'b1;
            state_in          = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         evict_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         evict_ff     <= evict_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff           <= mode_in;
      id_ff             <= id_in;
      rate_ff           <= rate_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_evicted_ff    <= rsp_evicted_in;
      rsp_removed_id_ff <= rsp_removed_id_in;
      rsp_average_ff    <= rsp_average_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_evicted    = rsp_evicted_ff;
   assign rsp_removed_id = rsp_removed_id_ff;
   assign rsp_average    = rsp_average_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(SLOTS - 1))
      else $error("held count above capacity");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_REMOVE |=> count_ff == $past(count_ff) - 1'b1)
      else $error("remove did not drop the count");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIVIDE)
      else $error("divider finished outside the divide state");

   a_evict_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_evicted_ff |-> rsp_status_ff == ST_INSERT)
      else $error("eviction flagged on a non-insert result");

   a_insert_mode: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INSERT |-> mode_ff == MODE_INSERT)
      else $error("insert path entered on a remove word");
`endif

endmodule

`default_nettype wire

@@ design/cqwa_div.sv @@
// Iterative restoring divider, two quotient bits per cycle, for the rounded mean.
// Depends on cqwa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cqwa_div #(
   parameter int DW = 4
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            load,
   input  wire logic [DW+cqwa_pkg::AVG_W-1:0]   num,
   input  wire logic [DW-1:0]                   den,
   output logic                                 done,
   output logic [cqwa_pkg::AVG_W-1:0]           quotient
);
   import cqwa_pkg::*;

   localparam int STEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   logic [DW-1:0]     rem_ff, rem_in;
   logic [AVG_W-1:0]  quo_ff, quo_in;
   logic [DW-1:0]     den_ff;
   logic [STEP_W-1:0] step_ff;
   logic              active_ff;
   logic              done_ff;

   // quotient fits AVG_W bits, so the upper numerator bits are already below den
   always_comb begin
      logic [DW:0]      t;
      logic [DW-1:0]    r;
      logic [AVG_W-1:0] q;
      r = rem_ff;
      q = quo_ff;
      for (int i = 0; i < DIV_BITS_STEP; i++) begin
         t = {r, q[AVG_W-1]};
         q = {q[AVG_W-2:0], 1'b0};
         if (t >= {1'b0, den_ff}) begin
            r    = DW'(t - {1'b0, den_ff});
            q[0] = 1'b1;
         end else begin
            r = t[DW-1:0];
         end
      end
      rem_in = r;
      quo_in = q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         step_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         if (load) begin
            active_ff <= 1'b1;
            step_ff   <= STEP_W'(DIV_STEPS - 1);
         end else if (active_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == '0) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff <= num[DW+AVG_W-1:AVG_W];
         quo_ff <= num[AVG_W-1:0];
         den_ff <= den;
      end else if (active_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

@@ test/circular_queue_window_average_check.sv @@
`timescale 1ns / 1ps
// Checker for circular_queue_window_average: tracks queue contents and the running
// rate sum, predicts each result word and compares it field by field. Uses cqwa_pkg.

module circular_queue_window_average_check #(
   parameter int SLOTS = cqwa_pkg::SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic                          req_mode,
   input  logic [cqwa_pkg::ID_W-1:0]     req_item_id,
   input  logic [cqwa_pkg::RATE_W-1:0]   req_item_rate,
   input  logic                          rsp_valid,
   input  logic [cqwa_pkg::STATUS_W-1:0] rsp_status,
   input  logic                          rsp_evicted,
   input  logic [cqwa_pkg::ID_W-1:0]     rsp_removed_id,
   input  logic [cqwa_pkg::AVG_W-1:0]    rsp_average,
   output int                            fail_count,
   output int                            pending_count
);
   import cqwa_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                evicted;
      logic [ID_W-1:0]     removed_id;
      logic [AVG_W-1:0]    average;
   } queue_result_type;

   queue_result_type     expected_results[$];
   logic [ID_W-1:0]      held_ids   [SLOTS];
   logic [RATE_W-1:0]    held_rates [SLOTS];
   int                   oldest_slot;
   int                   free_slot;
   int                   held_items;
   int                   rate_total;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      oldest_slot   = 0;
      free_slot     = 0;
      held_items    = 0;
      rate_total    = 0;
   end

   function automatic void drop_oldest();
      rate_total  = rate_total - int'(held_rates[oldest_slot]);
      oldest_slot = (oldest_slot + 1) % SLOTS;
      held_items  = held_items - 1;
   endfunction

   function automatic queue_result_type apply_word(logic mode, logic [ID_W-1:0] id,
                                                   logic [RATE_W-1:0] rate);
      queue_result_type r;
      r = '0;
      if (mode == MODE_INSERT) begin
         if (held_items >= SLOTS - 1) begin
            drop_oldest();
            r.evicted = 1'b1;
         end
         held_ids[free_slot]   = id;
         held_rates[free_slot] = rate;
         free_slot  = (free_slot + 1) % SLOTS;
         held_items = held_items + 1;
         rate_total = rate_total + int'(rate);
         // round half up
         r.average = AVG_W'((2 * rate_total + held_items) / (2 * held_items));
         r.status  = ST_INSERT;
      end else if (held_items == 0) begin
         r.status = ST_EMPTY;
      end else begin
         r.removed_id = held_ids[oldest_slot];
         drop_oldest();
         r.status = ST_REMOVE;
      end
      return r;
   endfunction

   function automatic void check_field(string field, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $error("%s mismatch: expected %0d, actual %0d", field, exp_val, act_val);
         fail_count = fail_count + 1;
      end
   endfunction

   always @(posedge clock) begin
      queue_result_type want;
      if (reset) begin
         expected_results.delete();
         oldest_slot = 0;
         free_slot   = 0;
         held_items  = 0;
         rate_total  = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               $error("result word with nothing expected");
               fail_count = fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("evicted", want.evicted, rsp_evicted);
               check_field("removed_id", want.removed_id, rsp_removed_id);
               check_field("average", want.average, rsp_average);
            end
         end
         if (start && !busy)
            expected_results.push_back(apply_word(req_mode, req_item_id, req_item_rate));
      end
      pending_count = expected_results.size();
   end

endmodule

@@ test/circular_queue_window_average_test.sv @@
`timescale 1ns / 1ps
// Top of the circular_queue_window_average testbench: clock, reset and command
// stimulus. Depends on cqwa_pkg, the block and circular_queue_window_average_check.

module circular_queue_window_average_test;
   import cqwa_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_WORDS = 1250;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_mode;
   logic [ID_W-1:0]     req_item_id;
   logic [RATE_W-1:0]   req_item_rate;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_evicted;
   logic [ID_W-1:0]     rsp_removed_id;
   logic [AVG_W-1:0]    rsp_average;
   int                  fail_count;
   int                  pending_count;
   int                  cycle_count;
   logic                gaps_on;

   circular_queue_window_average u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_item_id    (req_item_id),
      .req_item_rate  (req_item_rate),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_evicted    (rsp_evicted),
      .rsp_removed_id (rsp_removed_id),
      .rsp_average    (rsp_average)
   );

   circular_queue_window_average_check u_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_item_id    (req_item_id),
      .req_item_rate  (req_item_rate),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_evicted    (rsp_evicted),
      .rsp_removed_id (rsp_removed_id),
      .rsp_average    (rsp_average),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("circular_queue_window_average_test: FAIL");
         $finish;
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic issue_word(input logic mode, input logic [ID_W-1:0] id,
                             input logic [RATE_W-1:0] rate);
      int gap;
      gap = gaps_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start         <= 1'b1;
      req_mode      <= mode;
      req_item_id   <= id;
      req_item_rate <= rate;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   initial begin
      int                insert_pct;
      logic              mode;
      logic [RATE_W-1:0] rate;

      reset         = 1'b1;
      start         = 1'b0;
      req_mode      = MODE_INSERT;
      req_item_id   = '0;
      req_item_rate = '0;
      gaps_on       = 1'b1;
      insert_pct    = 50;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty remove, half rounding, fill with max rates, eviction, drain
      issue_word(MODE_REMOVE, 10'h3FF, 8'hFF);
      issue_word(MODE_INSERT, 10'd0, 8'd0);
      issue_word(MODE_INSERT, 10'd1, 8'd1);
      issue_word(MODE_REMOVE, 10'd0, 8'd0);
      issue_word(MODE_REMOVE, 10'h2AA, 8'h55);
      issue_word(MODE_REMOVE, 10'h155, 8'hAA);
      for (int k = 0; k < 8; k++)
         issue_word(MODE_INSERT, ID_W'(1023 - k), 8'hFF);
      issue_word(MODE_INSERT, 10'h3FF, 8'd0);
      for (int k = 0; k < 7; k++)
         issue_word(MODE_REMOVE, 10'd0, 8'd0);
      issue_word(MODE_REMOVE, 10'd0, 8'd0);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 50 == 0) begin
            case ($urandom_range(0, 3))
               0: insert_pct = 15;
               1: insert_pct = 50;
               2: insert_pct = 80;
               default: insert_pct = 95;
            endcase
            gaps_on = ($urandom_range(0, 3) != 0);
         end
         mode = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
         case ($urandom_range(0, 7))
            0: rate = 8'd0;
            1: rate = 8'hFF;
            default: rate = RATE_W'($urandom_range(0, 255));
         endcase
         issue_word(mode, ID_W'($urandom_range(0, 1023)), rate);
      end

      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (16) @(negedge clock);
      if (fail_count == 0)
         $display("circular_queue_window_average_test: PASS");
      else
         $display("circular_queue_window_average_test: FAIL");
      $finish;
   end

endmodule
